// ===== rtl/tasc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Angle sensor calibrator package
// Shared widths, register indexes, reset values and the channel low-pass
// filter used by the calibrator and its channel interfaces.
// ----------------------------------------------------------------------------
package tasc_pkg;

   // ADC sample and tracker width
   localparam int ADC_BITS = 10;
   // Width of the error value and its saturated maximum
   localparam int ERR_BITS = 28;
   localparam logic [ERR_BITS-1:0] ERR_MAX = '1;

   // Configuration port
   localparam int CSR_DATA_BITS = 20;
   localparam int PHASE_BITS    = 20;

   typedef enum logic [1:0] {
      CSR_FIRST_PHASE  = 2'd0,
      CSR_SECOND_PHASE = 2'd1,
      CSR_MIN_FLOOR    = 2'd2,
      CSR_MIN_START    = 2'd3
   } csr_index_type;

   // Register reset values
   localparam logic [PHASE_BITS-1:0] FIRST_PHASE_RESET  = 20'd400000;
   localparam logic [PHASE_BITS-1:0] SECOND_PHASE_RESET = 20'd18000;
   localparam logic [ADC_BITS-1:0]   MIN_FLOOR_RESET    = 10'd15;
   localparam logic [ADC_BITS-1:0]   MIN_START_RESET    = 10'd1000;

   // Filter: floor((sample + 4*prev) / 5) by reciprocal multiply.
   // The sum stays below 5120, where 13108 / 2^16 is exact after the floor.
   localparam int FILT_SUM_BITS  = ADC_BITS + 3;
   localparam int FILT_SHIFT     = 16;
   localparam int FILT_PROD_BITS = FILT_SUM_BITS + FILT_SHIFT;
   localparam logic [FILT_SHIFT-1:0] FILT_RECIP = 16'd13108;

   function automatic logic [ADC_BITS-1:0] lowpass(input logic [ADC_BITS-1:0] sample,
                                                   input logic [ADC_BITS-1:0] prev);
      logic [FILT_SUM_BITS-1:0]  sum;
      logic [FILT_PROD_BITS-1:0] prod;
      sum  = FILT_SUM_BITS'(sample) + {1'b0, prev, 2'b00};
      prod = FILT_PROD_BITS'(sum) * FILT_PROD_BITS'(FILT_RECIP);
      return prod[FILT_SHIFT +: ADC_BITS];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/tasc_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample pair channel
// Valid/ready channel that carries one raw ADC sample pair per beat.
// ----------------------------------------------------------------------------
interface tasc_req_if;
   import tasc_pkg::*;

   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] sample_a;
   logic [ADC_BITS-1:0] sample_b;

   modport source (output valid, output sample_a, output sample_b, input ready);
   modport sink   (input valid, input sample_a, input sample_b, output ready);

endinterface
`default_nettype wire

// ===== rtl/tasc_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calibration result channel
// Valid/ready channel that carries one complete calibration result per beat.
// ----------------------------------------------------------------------------
interface tasc_rsp_if;
   import tasc_pkg::*;

   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] low_a;
   logic [ADC_BITS-1:0] high_a;
   logic [ADC_BITS-1:0] low_b;
   logic [ADC_BITS-1:0] high_b;
   logic [ADC_BITS-1:0] zero_point_a;
   logic [ADC_BITS-1:0] zero_point_b;
   logic [ADC_BITS-1:0] half_turn_a;
   logic [ADC_BITS-1:0] half_turn_b;
   logic                range_fault;

   modport source (output valid, output low_a, output high_a, output low_b, output high_b,
                   output zero_point_a, output zero_point_b, output half_turn_a,
                   output half_turn_b, output range_fault, input ready);
   modport sink   (input valid, input low_a, input high_a, input low_b, input high_b,
                   input zero_point_a, input zero_point_b, input half_turn_a,
                   input half_turn_b, input range_fault, output ready);

endinterface
`default_nettype wire

// ===== rtl/two_channel_angle_sensor_calibrator.sv =====
// A sample pair goes from its beat through the TRACK, PREP, DIV, ERR and DONE states before
//   the next beat can be taken, so the calibrator works on one pair at a time.
// In DIV, two bit-serial restoring dividers retire one quotient bit per cycle.
// The result enters the output register once it is free or being taken; a full one stalls.
// Synchronous active-high reset sets state and configuration defaults and restarts calibration.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two channel angle sensor calibrator
// Filters sample pairs, tracks per-channel min and max, then searches for the
// 0 and 180 degree reference points with bit-serial normalizing dividers.
// ----------------------------------------------------------------------------
module two_channel_angle_sensor_calibrator #(
   parameter int ERROR_FRACTION_BITS = 16,
   parameter int COUNT_BITS          = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   tasc_req_if.sink                              req_ch,
   tasc_rsp_if.source                            rsp_ch,
   input  logic                                  csr_we,
   input  tasc_pkg::csr_index_type               csr_index,
   input  logic [tasc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import tasc_pkg::*;

   localparam int QUO_BITS  = ADC_BITS + ERROR_FRACTION_BITS;
   localparam int SUM_BITS  = QUO_BITS + 1;
   localparam int STEP_BITS = $clog2(QUO_BITS + 1);
   localparam int WIDE_BITS = (SUM_BITS > ERR_BITS) ? SUM_BITS : ERR_BITS;
   localparam int CMP_BITS  = ((COUNT_BITS > PHASE_BITS) ? COUNT_BITS : PHASE_BITS) + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TRACK,
      S_PREP,
      S_DIV,
      S_ERR,
      S_DONE
   } state_type;

   state_type state_ff;

   // Configuration registers
   logic [PHASE_BITS-1:0] first_len_ff;
   logic [PHASE_BITS-1:0] second_len_ff;
   logic [ADC_BITS-1:0]   floor_ff;
   logic [ADC_BITS-1:0]   start_ff;

   // Calibration state
   logic [ADC_BITS-1:0]   filt_a_ff, filt_b_ff;
   logic [ADC_BITS-1:0]   min_a_ff, max_a_ff, min_b_ff, max_b_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic                  phase2_ff;
   logic [ERR_BITS-1:0]   best_zero_ff, best_half_ff;
   logic [ADC_BITS-1:0]   zero_a_ff, zero_b_ff, half_a_ff, half_b_ff;

   // Divider and error datapath
   logic                  bad_ff;
   logic [ADC_BITS-1:0]   rng_a_ff, rng_b_ff;
   logic [ADC_BITS-1:0]   rem_a_ff, rem_b_ff;
   logic [QUO_BITS-1:0]   dq_a_ff, dq_b_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [ERR_BITS-1:0]   err_ff;

   // Output register
   logic                  rsp_valid_ff;
   logic [ADC_BITS-1:0]   rsp_low_a_ff, rsp_high_a_ff, rsp_low_b_ff, rsp_high_b_ff;
   logic [ADC_BITS-1:0]   rsp_zero_a_ff, rsp_zero_b_ff, rsp_half_a_ff, rsp_half_b_ff;
   logic                  rsp_fault_ff;

   // Next values
   logic [ADC_BITS-1:0]   filt_a_in, filt_b_in;
   logic [ADC_BITS-1:0]   rem_a_in, rem_b_in;
   logic                  qbit_a, qbit_b;
   logic [ERR_BITS-1:0]   err_in;
   logic [ADC_BITS-1:0]   zero_a_in, zero_b_in, half_a_in, half_b_in;
   logic [ERR_BITS-1:0]   best_zero_in, best_half_in;
   logic [CMP_BITS-1:0]   count_inc;
   logic                  last_pair;

   logic                  accept;
   logic                  rsp_taken;
   logic                  rsp_load;

   assign accept    = req_ch.valid && req_ch.ready;
   assign rsp_taken = rsp_valid_ff && rsp_ch.ready;

   // Load the output register on the last pair once it is free
   assign rsp_load  = (state_ff == S_DONE) && phase2_ff && last_pair &&
                      (!rsp_valid_ff || rsp_ch.ready);

   // Filter the incoming pair
   assign filt_a_in = lowpass(req_ch.sample_a, filt_a_ff);
   assign filt_b_in = lowpass(req_ch.sample_b, filt_b_ff);

   // One restoring division step per channel
   always_comb begin
      logic [ADC_BITS:0] shift_a, shift_b, diff_a, diff_b;
      shift_a  = {rem_a_ff, dq_a_ff[QUO_BITS-1]};
      shift_b  = {rem_b_ff, dq_b_ff[QUO_BITS-1]};
      diff_a   = shift_a - {1'b0, rng_a_ff};
      diff_b   = shift_b - {1'b0, rng_b_ff};
      qbit_a   = shift_a >= {1'b0, rng_a_ff};
      qbit_b   = shift_b >= {1'b0, rng_b_ff};
      rem_a_in = qbit_a ? diff_a[ADC_BITS-1:0] : shift_a[ADC_BITS-1:0];
      rem_b_in = qbit_b ? diff_b[ADC_BITS-1:0] : shift_b[ADC_BITS-1:0];
   end

   // Absolute deviation of the ratio sum from one, saturated; the maximum for a bad range
   always_comb begin
      logic [SUM_BITS-1:0]  sum, one, dev;
      logic [WIDE_BITS-1:0] wide;
      sum  = SUM_BITS'(dq_a_ff) + SUM_BITS'(dq_b_ff);
      one  = SUM_BITS'(1) << ERROR_FRACTION_BITS;
      dev  = (sum >= one) ? (sum - one) : (one - sum);
      wide = WIDE_BITS'(dev);
      if (bad_ff || (wide > WIDE_BITS'(ERR_MAX))) begin
         err_in = ERR_MAX;
      end else begin
         err_in = wide[ERR_BITS-1:0];
      end
   end

   // Reference point capture and phase counting
   always_comb begin
      logic [CMP_BITS-1:0] cfg_len, span, len;
      logic                take_zero, take_half;
      take_zero    = (err_ff < best_zero_ff) && (filt_a_ff > filt_b_ff);
      take_half    = (err_ff < best_half_ff) && (filt_a_ff < filt_b_ff);
      zero_a_in    = take_zero ? filt_a_ff : zero_a_ff;
      zero_b_in    = take_zero ? filt_b_ff : zero_b_ff;
      best_zero_in = take_zero ? err_ff : best_zero_ff;
      half_a_in    = take_half ? filt_a_ff : half_a_ff;
      half_b_in    = take_half ? filt_b_ff : half_b_ff;
      best_half_in = take_half ? err_ff : best_half_ff;

      cfg_len   = CMP_BITS'(phase2_ff ? second_len_ff : first_len_ff);
      span      = CMP_BITS'(1) << COUNT_BITS;
      if (cfg_len == '0) begin
         len = CMP_BITS'(1);
      end else if (cfg_len > span) begin
         len = span;
      end else begin
         len = cfg_len;
      end
      count_inc = CMP_BITS'(count_ff) + CMP_BITS'(1);
      last_pair = count_inc >= len;
   end

   // Sequencer, configuration and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         first_len_ff  <= FIRST_PHASE_RESET;
         second_len_ff <= SECOND_PHASE_RESET;
         floor_ff      <= MIN_FLOOR_RESET;
         start_ff      <= MIN_START_RESET;
         filt_a_ff     <= '0;
         filt_b_ff     <= '0;
         min_a_ff      <= MIN_START_RESET;
         min_b_ff      <= MIN_START_RESET;
         max_a_ff      <= '0;
         max_b_ff      <= '0;
         count_ff      <= '0;
         phase2_ff     <= 1'b0;
         best_zero_ff  <= ERR_MAX;
         best_half_ff  <= ERR_MAX;
         zero_a_ff     <= '0;
         zero_b_ff     <= '0;
         half_a_ff     <= '0;
         half_b_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // Register writes
         if (csr_we) begin
            case (csr_index)
               CSR_FIRST_PHASE:  first_len_ff  <= csr_wdata[PHASE_BITS-1:0];
               CSR_SECOND_PHASE: second_len_ff <= csr_wdata[PHASE_BITS-1:0];
               CSR_MIN_FLOOR:    floor_ff      <= csr_wdata[ADC_BITS-1:0];
               CSR_MIN_START:    start_ff      <= csr_wdata[ADC_BITS-1:0];
               default: ;
            endcase
         end

         // Drop the result once its beat is taken, unless a new one replaces it
         if (rsp_taken && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  filt_a_ff <= filt_a_in;
                  filt_b_ff <= filt_b_in;
                  state_ff  <= S_TRACK;
               end
            end

            // Update the trackers during phase one
            S_TRACK: begin
               if (!phase2_ff) begin
                  if ((min_a_ff > filt_a_ff) && (filt_a_ff > floor_ff)) begin
                     min_a_ff <= filt_a_ff;
                  end
                  if (max_a_ff < filt_a_ff) begin
                     max_a_ff <= filt_a_ff;
                  end
                  if ((min_b_ff > filt_b_ff) && (filt_b_ff > floor_ff)) begin
                     min_b_ff <= filt_b_ff;
                  end
                  if (max_b_ff < filt_b_ff) begin
                     max_b_ff <= filt_b_ff;
                  end
               end
               state_ff <= S_PREP;
            end

            // Load the dividers with f << fraction bits over the channel range
            S_PREP: begin
               rng_a_ff <= max_a_ff - min_a_ff;
               rng_b_ff <= max_b_ff - min_b_ff;
               bad_ff   <= (max_a_ff <= min_a_ff) || (max_b_ff <= min_b_ff);
               rem_a_ff <= '0;
               rem_b_ff <= '0;
               dq_a_ff  <= QUO_BITS'(filt_a_ff) << ERROR_FRACTION_BITS;
               dq_b_ff  <= QUO_BITS'(filt_b_ff) << ERROR_FRACTION_BITS;
               step_ff  <= '0;
               state_ff <= S_DIV;
            end

            // Shift one quotient bit per cycle into each divider
            S_DIV: begin
               rem_a_ff <= rem_a_in;
               rem_b_ff <= rem_b_in;
               dq_a_ff  <= {dq_a_ff[QUO_BITS-2:0], qbit_a};
               dq_b_ff  <= {dq_b_ff[QUO_BITS-2:0], qbit_b};
               step_ff  <= step_ff + STEP_BITS'(1);
               if (step_ff == STEP_BITS'(QUO_BITS - 1)) begin
                  state_ff <= S_ERR;
               end
            end

            S_ERR: begin
               err_ff   <= err_in;
               state_ff <= S_DONE;
            end

            S_DONE: begin
               if (!phase2_ff) begin
                  // End of phase one seeds both best errors
                  if (last_pair) begin
                     best_zero_ff <= err_ff;
                     best_half_ff <= err_ff;
                     count_ff     <= '0;
                     phase2_ff    <= 1'b1;
                  end else begin
                     count_ff <= count_inc[COUNT_BITS-1:0];
                  end
                  state_ff <= S_IDLE;
               end else if (!last_pair) begin
                  best_zero_ff <= best_zero_in;
                  best_half_ff <= best_half_in;
                  zero_a_ff    <= zero_a_in;
                  zero_b_ff    <= zero_b_in;
                  half_a_ff    <= half_a_in;
                  half_b_ff    <= half_b_in;
                  count_ff     <= count_inc[COUNT_BITS-1:0];
                  state_ff     <= S_IDLE;
               end else if (rsp_load) begin
                  // Emit the result and re-arm
                  rsp_valid_ff  <= 1'b1;
                  rsp_low_a_ff  <= min_a_ff;
                  rsp_high_a_ff <= max_a_ff;
                  rsp_low_b_ff  <= min_b_ff;
                  rsp_high_b_ff <= max_b_ff;
                  rsp_zero_a_ff <= zero_a_in;
                  rsp_zero_b_ff <= zero_b_in;
                  rsp_half_a_ff <= half_a_in;
                  rsp_half_b_ff <= half_b_in;
                  rsp_fault_ff  <= bad_ff;
                  filt_a_ff     <= '0;
                  filt_b_ff     <= '0;
                  min_a_ff      <= start_ff;
                  min_b_ff      <= start_ff;
                  max_a_ff      <= '0;
                  max_b_ff      <= '0;
                  count_ff      <= '0;
                  phase2_ff     <= 1'b0;
                  best_zero_ff  <= ERR_MAX;
                  best_half_ff  <= ERR_MAX;
                  zero_a_ff     <= '0;
                  zero_b_ff     <= '0;
                  half_a_ff     <= '0;
                  half_b_ff     <= '0;
                  state_ff      <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Channel ports
   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.low_a        = rsp_low_a_ff;
   assign rsp_ch.high_a       = rsp_high_a_ff;
   assign rsp_ch.low_b        = rsp_low_b_ff;
   assign rsp_ch.high_b       = rsp_high_b_ff;
   assign rsp_ch.zero_point_a = rsp_zero_a_ff;
   assign rsp_ch.zero_point_b = rsp_zero_b_ff;
   assign rsp_ch.half_turn_a  = rsp_half_a_ff;
   assign rsp_ch.half_turn_b  = rsp_half_b_ff;
   assign rsp_ch.range_fault  = rsp_fault_ff;

endmodule
`default_nettype wire

// ===== rtl/tasc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Angle sensor calibrator port checker
// Watches the calibrator's channel ports and flags illegal sequences.
// ----------------------------------------------------------------------------
module tasc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tasc_pkg::ADC_BITS-1:0] rsp_low_a,
   input logic [tasc_pkg::ADC_BITS-1:0] rsp_high_a,
   input logic [tasc_pkg::ADC_BITS-1:0] rsp_low_b,
   input logic [tasc_pkg::ADC_BITS-1:0] rsp_high_b,
   input logic                          rsp_range_fault
);
   import tasc_pkg::*;

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_low_a) && $stable(rsp_high_b))
      else $error("result beat changed while stalled");

   // Reset drops any pending result
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One pair at a time: ready drops after every accepted beat
   a_req_serial: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat accepted while a pair is in work");

   // A result only appears while a pair is in work
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a pair in work");

   // A result without fault has a positive range on both channels
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_range_fault |-> (rsp_high_a > rsp_low_a) && (rsp_high_b > rsp_low_b))
      else $error("fault flag clear with an empty channel range");

endmodule

bind two_channel_angle_sensor_calibrator tasc_checker u_tasc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_low_a       (rsp_ch.low_a),
   .rsp_high_a      (rsp_ch.high_a),
   .rsp_low_b       (rsp_ch.low_b),
   .rsp_high_b      (rsp_ch.high_b),
   .rsp_range_fault (rsp_ch.range_fault)
);
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle sensor calibrator testbench
// Streams ADC sample pairs into the calibrator, predicts every calibration
// result from its own copy of filter, tracker and reference point search
// state, and checks each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   import tasc_pkg::*;

   localparam int FRAC_BITS     = 16;
   localparam int CNT_BITS      = 20;
   localparam int IDLE_CYCLES   = 40;
   localparam int LONG_HOLD     = 800;
   localparam int PAIR_TARGET   = 1800;
   localparam int RESULT_TARGET = 40;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [ADC_BITS-1:0] low_a;
      logic [ADC_BITS-1:0] high_a;
      logic [ADC_BITS-1:0] low_b;
      logic [ADC_BITS-1:0] high_b;
      logic [ADC_BITS-1:0] zero_point_a;
      logic [ADC_BITS-1:0] zero_point_b;
      logic [ADC_BITS-1:0] half_turn_a;
      logic [ADC_BITS-1:0] half_turn_b;
      logic                range_fault;
   } calib_result_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_we;
   csr_index_type            csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   tasc_req_if req_bus ();
   tasc_rsp_if rsp_bus ();

   two_channel_angle_sensor_calibrator #(
      .ERROR_FRACTION_BITS(FRAC_BITS),
      .COUNT_BITS(CNT_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Predicted calibrations still waiting for their result beat
   calib_result_type pending_calibrations[$];

   // Register copies
   logic [PHASE_BITS-1:0] cfg_first;
   logic [PHASE_BITS-1:0] cfg_second;
   logic [ADC_BITS-1:0]   cfg_floor;
   logic [ADC_BITS-1:0]   cfg_start;

   // Calibrator state as predicted
   logic [ADC_BITS-1:0]   mdl_filt_a, mdl_filt_b;
   logic [ADC_BITS-1:0]   mdl_min_a, mdl_max_a, mdl_min_b, mdl_max_b;
   logic [PHASE_BITS-1:0] mdl_count;
   logic                  mdl_searching;
   logic [ERR_BITS-1:0]   mdl_err_zero, mdl_err_half;
   logic [ADC_BITS-1:0]   mdl_point [4];

   // Sweep generator state
   int sweep_pos, sweep_amp, sweep_off;

   int   pairs_sent      = 0;
   int   results_checked = 0;
   int   fault_results   = 0;
   int   error_count     = 0;
   int   rsp_stall       = 0;
   logic no_idle         = 1'b0;
   logic hold_request    = 1'b0;
   logic rsp_holding     = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int draw_gap();
      if (no_idle) begin
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------
   function automatic logic [ADC_BITS-1:0] smooth(input logic [ADC_BITS-1:0] sample,
                                                  input logic [ADC_BITS-1:0] prev);
      int sum;
      sum = int'(sample) + 4 * int'(prev);
      return ADC_BITS'(sum / 5);
   endfunction

   function automatic logic ranges_bad();
      return (mdl_max_a <= mdl_min_a) || (mdl_max_b <= mdl_min_b);
   endfunction

   function automatic logic [ERR_BITS-1:0] match_error();
      logic [ADC_BITS-1:0] span_a, span_b;
      logic [31:0]         q, one, e;
      if (ranges_bad()) begin
         return ERR_MAX;
      end
      span_a = mdl_max_a - mdl_min_a;
      span_b = mdl_max_b - mdl_min_b;
      one = 32'd1 << FRAC_BITS;
      q = (32'(mdl_filt_a) << FRAC_BITS) / 32'(span_a)
        + (32'(mdl_filt_b) << FRAC_BITS) / 32'(span_b);
      e = (q >= one) ? q - one : one - q;
      return (e > 32'(ERR_MAX)) ? ERR_MAX : e[ERR_BITS-1:0];
   endfunction

   // A zero length runs one pair
   function automatic logic [PHASE_BITS:0] phase_limit(input logic [PHASE_BITS-1:0] len);
      return (len == '0) ? (PHASE_BITS+1)'(1) : {1'b0, len};
   endfunction

   function automatic int pairs_in_phase(input logic [PHASE_BITS-1:0] len);
      return (len == '0) ? 1 : int'(len);
   endfunction

   function automatic void rearm_model();
      mdl_filt_a    = '0;
      mdl_filt_b    = '0;
      mdl_min_a     = cfg_start;
      mdl_min_b     = cfg_start;
      mdl_max_a     = '0;
      mdl_max_b     = '0;
      mdl_count     = '0;
      mdl_searching = 1'b0;
      mdl_err_zero  = ERR_MAX;
      mdl_err_half  = ERR_MAX;
      for (int k = 0; k < 4; k++) begin
         mdl_point[k] = '0;
      end
   endfunction

   // Advance the predicted calibrator by one accepted pair
   task automatic calibrate_pair(input logic [ADC_BITS-1:0] a, input logic [ADC_BITS-1:0] b);
      logic [ERR_BITS-1:0]   err;
      logic [PHASE_BITS:0]   next_count;
      calib_result_type      res;
      mdl_filt_a = smooth(a, mdl_filt_a);
      mdl_filt_b = smooth(b, mdl_filt_b);
      next_count = {1'b0, mdl_count} + 1'b1;
      if (!mdl_searching) begin
         // track the extremes; the minimum only moves above the floor
         if (mdl_min_a > mdl_filt_a && mdl_filt_a > cfg_floor) mdl_min_a = mdl_filt_a;
         if (mdl_max_a < mdl_filt_a) mdl_max_a = mdl_filt_a;
         if (mdl_min_b > mdl_filt_b && mdl_filt_b > cfg_floor) mdl_min_b = mdl_filt_b;
         if (mdl_max_b < mdl_filt_b) mdl_max_b = mdl_filt_b;
         if (next_count >= phase_limit(cfg_first)) begin
            // seed both searches from the last tracking pair
            err           = match_error();
            mdl_err_zero  = err;
            mdl_err_half  = err;
            mdl_count     = '0;
            mdl_searching = 1'b1;
         end else begin
            mdl_count = next_count[PHASE_BITS-1:0];
         end
         return;
      end
      // search: take a point only on a strictly smaller error
      err = match_error();
      if (err < mdl_err_zero && mdl_filt_a > mdl_filt_b) begin
         mdl_err_zero = err;
         mdl_point[0] = mdl_filt_a;
         mdl_point[1] = mdl_filt_b;
      end
      if (err < mdl_err_half && mdl_filt_a < mdl_filt_b) begin
         mdl_err_half = err;
         mdl_point[2] = mdl_filt_a;
         mdl_point[3] = mdl_filt_b;
      end
      if (next_count < phase_limit(cfg_second)) begin
         mdl_count = next_count[PHASE_BITS-1:0];
         return;
      end
      res.low_a        = mdl_min_a;
      res.high_a       = mdl_max_a;
      res.low_b        = mdl_min_b;
      res.high_b       = mdl_max_b;
      res.zero_point_a = mdl_point[0];
      res.zero_point_b = mdl_point[1];
      res.half_turn_a  = mdl_point[2];
      res.half_turn_b  = mdl_point[3];
      res.range_fault  = ranges_bad();
      pending_calibrations.push_back(res);
      rearm_model();
   endtask

   // ---------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FIRST_PHASE:  cfg_first  = data[PHASE_BITS-1:0];
         CSR_SECOND_PHASE: cfg_second = data[PHASE_BITS-1:0];
         CSR_MIN_FLOOR:    cfg_floor  = data[ADC_BITS-1:0];
         CSR_MIN_START:    cfg_start  = data[ADC_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_phases(input int first_len, input int second_len);
      write_reg(CSR_FIRST_PHASE, CSR_DATA_BITS'(first_len));
      write_reg(CSR_SECOND_PHASE, CSR_DATA_BITS'(second_len));
   endtask

   task automatic set_minimum(input int floor_val, input int start_val);
      write_reg(CSR_MIN_FLOOR, CSR_DATA_BITS'(floor_val));
      write_reg(CSR_MIN_START, CSR_DATA_BITS'(start_val));
   endtask

   // Offer one pair after a random gap and hold it until the beat is taken
   task automatic send_pair(input logic [ADC_BITS-1:0] a, input logic [ADC_BITS-1:0] b);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.sample_a <= a;
      req_bus.sample_b <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pairs_sent++;
      calibrate_pair(a, b);
   endtask

   // Drop valid, drain all pending results, then let the last pair retire
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_calibrations.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   function automatic void new_sweep();
      sweep_pos = $urandom_range(0, 2047);
      sweep_off = $urandom_range(0, 200);
      sweep_amp = $urandom_range(64, 1023 - sweep_off);
   endfunction

   // Mostly a two-channel triangle sweep, with noise and rail hits mixed in
   task automatic next_pair(output logic [ADC_BITS-1:0] a, output logic [ADC_BITS-1:0] b);
      int pick, t, span, va, vb;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         sweep_pos = sweep_pos + $urandom_range(1, 64);
         t = sweep_pos % 2048;
         if (t >= 1024) t = 2047 - t;
         span = t * sweep_amp / 1023;
         va = sweep_off + span;
         vb = sweep_off + sweep_amp - span + $urandom_range(0, 3);
         if (vb > 1023) vb = 1023;
         a = ADC_BITS'(va);
         b = ADC_BITS'(vb);
      end else if (pick < 95) begin
         a = ADC_BITS'($urandom_range(0, 1023));
         b = ADC_BITS'($urandom_range(0, 1023));
      end else begin
         a = $urandom_range(0, 1) ? '1 : '0;
         b = $urandom_range(0, 1) ? '1 : '0;
      end
   endtask

   task automatic send_random_pairs(input int count);
      logic [ADC_BITS-1:0] a, b;
      repeat (count) begin
         next_pair(a, b);
         send_pair(a, b);
      end
   endtask

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   function automatic void show_result(input string tag, input calib_result_type r);
      $display("%s low_a=%0d high_a=%0d low_b=%0d high_b=%0d zero=%0d/%0d half=%0d/%0d fault=%0d",
               tag, r.low_a, r.high_a, r.low_b, r.high_b, r.zero_point_a, r.zero_point_b,
               r.half_turn_a, r.half_turn_b, r.range_fault);
   endfunction

   task automatic check_result();
      calib_result_type got, want;
      got.low_a        = rsp_bus.low_a;
      got.high_a       = rsp_bus.high_a;
      got.low_b        = rsp_bus.low_b;
      got.high_b       = rsp_bus.high_b;
      got.zero_point_a = rsp_bus.zero_point_a;
      got.zero_point_b = rsp_bus.zero_point_b;
      got.half_turn_a  = rsp_bus.half_turn_a;
      got.half_turn_b  = rsp_bus.half_turn_b;
      got.range_fault  = rsp_bus.range_fault;
      results_checked++;
      if (got.range_fault === 1'b1) fault_results++;
      if (pending_calibrations.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $display("tb: result beat %0d arrived with no calibration pending", results_checked);
         end
         return;
      end
      want = pending_calibrations.pop_front();
      if (got !== want) begin
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $display("tb: result beat %0d differs", results_checked);
            show_result("  expected", want);
            show_result("  actual  ", got);
         end
      end
   endtask

   // Take result beats; stall each waiting result by a drawn number of cycles
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         check_result();
         rsp_stall = draw_gap();
      end else if (rsp_bus.valid === 1'b1 && rsp_stall != 0) begin
         rsp_stall--;
      end
      rsp_bus.ready <= (rsp_stall == 0) && !rsp_holding;
   end

   // Long receiver hold-off, counted here in cycles
   initial begin : rsp_hold_off
      forever begin
         wait (hold_request);
         rsp_holding <= 1'b1;
         repeat (LONG_HOLD) @(posedge clock);
         rsp_holding <= 1'b0;
         wait (!hold_request);
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset floor and start values, rail samples on both channels
   task automatic test_default_trackers();
      set_phases(3, 2);
      send_pair(10'd0, 10'd1023);
      send_pair(10'd1023, 10'd0);
      send_pair(10'd1023, 10'd1023);
      send_pair(10'd1023, 10'd0);
      send_pair(10'd0, 10'd1023);
      wait_idle();
   endtask

   // Zero length runs one pair; then the shortest real lengths
   task automatic test_single_pair_phases();
      set_phases(0, 0);
      send_pair(10'd1023, 10'd0);
      send_pair(10'd0, 10'd1023);
      wait_idle();
      set_phases(1, 1);
      send_pair(10'd1023, 10'd1023);
      send_pair(10'd1023, 10'd0);
      wait_idle();
   endtask

   // Flat input leaves no range, so every error saturates
   task automatic test_range_fault();
      set_phases(2, 2);
      repeat (4) send_pair(10'd0, 10'd0);
      wait_idle();
   endtask

   // Equal channels never qualify, so both points stay zero
   task automatic test_equal_channels();
      set_phases(2, 2);
      repeat (4) send_pair(10'd700, 10'd700);
      wait_idle();
   endtask

   // Floor and start at both ends; start only lands at the next re-arm
   task automatic test_minimum_limits();
      set_minimum(1023, 0);
      set_phases(2, 2);
      repeat (2) begin
         send_pair(10'd1023, 10'd512);
         send_pair(10'd512, 10'd1023);
         send_pair(10'd1023, 10'd0);
         send_pair(10'd0, 10'd1023);
         wait_idle();
      end
      set_minimum(0, 1023);
   endtask

   // Full-count phase lengths, cut short by writes in the middle of a run
   task automatic test_wide_phase_lengths();
      set_phases(1048575, 1048575);
      new_sweep();
      send_random_pairs(12);
      wait_idle();
      write_reg(CSR_FIRST_PHASE, CSR_DATA_BITS'(5));
      send_random_pairs(6);
      wait_idle();
      write_reg(CSR_SECOND_PHASE, CSR_DATA_BITS'(4));
      send_random_pairs(1);
      wait_idle();
      set_minimum(15, 1000);
   endtask

   // Hold results off while pairs keep coming, so the input backs up
   task automatic test_back_pressure();
      set_phases(1, 1);
      new_sweep();
      hold_request = 1'b1;
      no_idle = 1'b1;
      send_random_pairs(8);
      no_idle = 1'b0;
      hold_request = 1'b0;
      wait_idle();
   endtask

   // Random settings per calibration, mostly short phases
   task automatic test_random_calibrations();
      logic [PHASE_BITS-1:0] first_len, second_len;
      int                    floor_val, start_val;
      while (pairs_sent < PAIR_TARGET || results_checked < RESULT_TARGET) begin
         case ($urandom_range(0, 9))
            0: first_len = '0;
            1: first_len = PHASE_BITS'(1);
            default: first_len = PHASE_BITS'($urandom_range(2, 40));
         endcase
         case ($urandom_range(0, 9))
            0: second_len = '0;
            1: second_len = PHASE_BITS'(1);
            default: second_len = PHASE_BITS'($urandom_range(2, 30));
         endcase
         case ($urandom_range(0, 9))
            0: floor_val = 0;
            1: floor_val = 1023;
            2, 3: floor_val = $urandom_range(0, 1023);
            default: floor_val = $urandom_range(0, 40);
         endcase
         case ($urandom_range(0, 9))
            0: start_val = 0;
            1: start_val = 1023;
            2, 3, 4: start_val = $urandom_range(0, 1023);
            default: start_val = $urandom_range(800, 1023);
         endcase
         set_phases(int'(first_len), int'(second_len));
         set_minimum(floor_val, start_val);
         new_sweep();
         no_idle = ($urandom_range(0, 5) == 0);
         send_random_pairs(pairs_in_phase(first_len) + pairs_in_phase(second_len));
         no_idle = 1'b0;
         wait_idle();
      end
   endtask

   initial begin
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= CSR_FIRST_PHASE;
      csr_wdata        <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.sample_a <= '0;
      req_bus.sample_b <= '0;
      cfg_first  = 20'd400000;
      cfg_second = 20'd18000;
      cfg_floor  = 10'd15;
      cfg_start  = 10'd1000;
      rearm_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_default_trackers();
      test_single_pair_phases();
      test_range_fault();
      test_equal_channels();
      test_minimum_limits();
      test_wide_phase_lengths();
      test_back_pressure();
      test_random_calibrations();
      wait_idle();

      $display("tb: %0d sample pairs, %0d calibration results checked (%0d range faults)",
               pairs_sent, results_checked, fault_results);
      $display("tb: phases from one pair to full count, floor/start at both ends, long stall");
      if (error_count == 0 && pending_calibrations.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tasc_pkg.sv
rtl/tasc_req_if.sv
rtl/tasc_rsp_if.sv
rtl/two_channel_angle_sensor_calibrator.sv
rtl/tasc_checker.sv
dv/tb.sv
